// ----- design/cspan_pkg.sv -----
`timescale 1ns / 1ps

package cspan_pkg;

    localparam int MAX_RADIUS = 32;
    localparam int MAX_DIM    = 4096;
    localparam int MOD_STEPS  = 14;

    typedef logic [12:0] t_dim;
    typedef logic [11:0] t_coord;

    // Clamped frame size, fixed by the user unless the block is idle; the block does not enforce it
    typedef struct packed {
        t_dim width;
        t_dim height;
    } t_frame;

    // One circle, with its first row and center column already wrapped
    typedef struct packed {
        t_coord      row_start;
        t_coord      col_start;
        logic [5:0]  radius;
        logic [31:0] value;
    } t_job;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MODX,
        F_MODY,
        F_PUSH
    } t_front_state;

    typedef enum logic {
        B_IDLE,
        B_ROW
    } t_back_state;

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_index;

    function automatic t_dim clamp_dim(input logic [12:0] d);
        t_dim res;
        if (d == 13'd0) begin
            res = 13'd1;
        end else if (d > 13'(MAX_DIM)) begin
            res = 13'(MAX_DIM);
        end else begin
            res = d;
        end
        return res;
    endfunction

    function automatic logic [11:0] sq6(input logic [5:0] a);
        logic [11:0] ae;
        ae = {6'd0, a};
        return ae * ae;
    endfunction

endpackage

// ----- design/cspan_mod_unit.sv -----
`timescale 1ns / 1ps

// Restoring remainder of a 15-bit two's complement value by a modulus of
// 1..4096, one quotient bit per cycle; result is always in [0, modulus).
module cspan_mod_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [14:0]           i_value,
    input  cspan_pkg::t_dim       i_modulus,
    output logic                  o_done,
    output cspan_pkg::t_coord     o_result
);

    logic        r_busy;
    logic        r_done;
    logic [3:0]  r_cnt;
    logic [13:0] r_mag;
    logic [12:0] r_rem;
    logic        r_neg;

    logic [14:0] abs_v;
    logic [13:0] trial;
    logic [13:0] diff;
    logic [12:0] n_rem;

    assign abs_v = i_value[14] ? 15'(-i_value) : i_value;
    assign trial = {r_rem, r_mag[13]};
    assign diff  = trial - {1'b0, i_modulus};
    assign n_rem = (trial >= {1'b0, i_modulus}) ? diff[12:0] : trial[12:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + 4'd1;
            if (r_cnt == 4'(cspan_pkg::MOD_STEPS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= abs_v[13:0];
            r_neg <= i_value[14];
            r_rem <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[12:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    // Fold a negative remainder back into range
    assign o_done   = r_done;
    assign o_result = (r_neg && (r_rem != 13'd0)) ? 12'(i_modulus - r_rem) : r_rem[11:0];

endmodule

// ----- design/cspan_front.sv -----
`timescale 1ns / 1ps

// Accept a circle, saturate its radius, drop empty circles, and wrap the
// center column and the first row before handing the job on.
module cspan_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [13:0]           i_center_x,
    input  logic [13:0]           i_center_y,
    input  logic [5:0]            i_circle_radius,
    input  logic [31:0]           i_fill_value,
    input  cspan_pkg::t_frame     i_frame,
    input  logic                  i_q_full,
    output logic                  o_push,
    output cspan_pkg::t_job       o_job
);

    cspan_pkg::t_front_state r_state, n_state;

    logic [13:0]       r_cy;
    logic [5:0]        r_radius;
    logic [31:0]       r_value;
    cspan_pkg::t_coord r_col;
    cspan_pkg::t_coord r_row;

    logic              accept;
    logic              take;
    logic [5:0]        clamped_r;
    logic              mod_start;
    logic [14:0]       mod_value;
    cspan_pkg::t_dim   mod_modulus;
    logic              mod_done;
    cspan_pkg::t_coord mod_result;

    assign clamped_r = (i_circle_radius > 6'(cspan_pkg::MAX_RADIUS)) ?
                       6'(cspan_pkg::MAX_RADIUS) : i_circle_radius;
    assign accept    = i_valid && !o_stall;
    assign take      = accept && (i_circle_radius != 6'd0);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cspan_pkg::F_IDLE: if (take) n_state = cspan_pkg::F_MODX;
            cspan_pkg::F_MODX: if (mod_done) n_state = cspan_pkg::F_MODY;
            cspan_pkg::F_MODY: if (mod_done) n_state = cspan_pkg::F_PUSH;
            cspan_pkg::F_PUSH: if (!i_q_full) n_state = cspan_pkg::F_IDLE;
            default:           n_state = cspan_pkg::F_IDLE;
        endcase
    end

    always_comb begin
        o_stall     = (r_state != cspan_pkg::F_IDLE);
        o_push      = 1'b0;
        mod_start   = 1'b0;
        mod_value   = {i_center_x[13], i_center_x};
        mod_modulus = i_frame.width;
        unique case (r_state)
            cspan_pkg::F_IDLE: begin
                mod_start = take;
            end
            cspan_pkg::F_MODX: begin
                // column still runs against the width; first row sits r-1
                // above the center and starts once the column is done
                mod_start   = mod_done;
                mod_value   = {r_cy[13], r_cy} - {9'd0, r_radius} + 15'd1;
            end
            cspan_pkg::F_MODY: begin
                mod_modulus = i_frame.height;
            end
            cspan_pkg::F_PUSH: begin
                o_push = !i_q_full;
            end
            default: begin
                o_push = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cspan_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cy     <= i_center_y;
            r_radius <= clamped_r;
            r_value  <= i_fill_value;
        end
        if (mod_done && (r_state == cspan_pkg::F_MODX)) begin
            r_col <= mod_result;
        end
        if (mod_done && (r_state == cspan_pkg::F_MODY)) begin
            r_row <= mod_result;
        end
    end

    cspan_mod_unit u_mod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mod_start),
        .i_value   (mod_value),
        .i_modulus (mod_modulus),
        .o_done    (mod_done),
        .o_result  (mod_result)
    );

    assign o_job.row_start = r_row;
    assign o_job.col_start = r_col;
    assign o_job.radius    = r_radius;
    assign o_job.value     = r_value;

endmodule

// ----- design/cspan_queue.sv -----
`timescale 1ns / 1ps

// Two-entry job queue between front and back.
module cspan_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cspan_pkg::t_job   i_job,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output cspan_pkg::t_job   o_job
);

    cspan_pkg::t_job r_mem [2];
    logic            r_wptr;
    logic            r_rptr;
    logic [1:0]      r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_job   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) r_wptr <= ~r_wptr;
            if (i_pop)  r_rptr <= ~r_rptr;
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

// ----- design/cspan_back.sv -----
`timescale 1ns / 1ps

// Walk the rows of one circle, moving the half width one pixel a cycle and
// keeping the wrapped start column in step, and emit one span per row.
module cspan_back (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  cspan_pkg::t_frame     i_frame,
    input  logic                  i_q_valid,
    input  cspan_pkg::t_job       i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [11:0]           o_row_y,
    output logic [11:0]           o_span_start_x,
    output logic [5:0]            o_span_length,
    output logic [31:0]           o_span_value,
    output logic                  o_last_span
);

    cspan_pkg::t_back_state r_state, n_state;

    cspan_pkg::t_coord r_row;
    cspan_pkg::t_coord r_col;
    logic [4:0]        r_h;
    logic [5:0]        r_radius;
    logic [6:0]        r_dy;
    logic [11:0]       r_dy2;
    logic [11:0]       r_r2;
    logic [31:0]       r_value;

    logic              r_out_valid;
    cspan_pkg::t_coord r_out_row;
    cspan_pkg::t_coord r_out_col;
    logic [5:0]        r_out_len;
    logic [31:0]       r_out_value;
    logic              r_out_last;

    logic              upper;
    logic [5:0]        sq_in;
    logic [11:0]       sum;
    logic              grow;
    logic              shrink;
    logic              out_free;
    logic              is_last;
    logic              load;
    logic              step;
    logic              emit;
    logic [6:0]        dy_next;
    logic [6:0]        dy_abs;
    cspan_pkg::t_coord wm1;
    cspan_pkg::t_coord hm1;

    assign wm1 = 12'(i_frame.width - 13'd1);
    assign hm1 = 12'(i_frame.height - 13'd1);

    // Upper half: try to widen by one; lower half: test whether to narrow
    assign upper    = r_dy[6] || (r_dy == 7'd0);
    assign sq_in    = upper ? ({1'b0, r_h} + 6'd1) : {1'b0, r_h};
    assign sum      = cspan_pkg::sq6(sq_in) + r_dy2;
    assign grow     = upper && (sum < r_r2);
    assign shrink   = !upper && (r_h != 5'd0) && (sum >= r_r2);
    assign out_free = !r_out_valid || !i_stall;
    assign is_last  = (r_dy == ({1'b0, r_radius} - 7'd1));
    assign dy_next  = r_dy + 7'd1;
    assign dy_abs   = dy_next[6] ? 7'(-dy_next) : dy_next;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            cspan_pkg::B_IDLE: if (i_q_valid) n_state = cspan_pkg::B_ROW;
            cspan_pkg::B_ROW:  if (emit && is_last) n_state = cspan_pkg::B_IDLE;
            default:           n_state = cspan_pkg::B_IDLE;
        endcase
    end

    always_comb begin
        load = 1'b0;
        step = 1'b0;
        emit = 1'b0;
        unique case (r_state)
            cspan_pkg::B_IDLE: load = i_q_valid;
            cspan_pkg::B_ROW: begin
                step = grow || shrink;
                emit = !grow && !shrink && out_free;
            end
            default: load = 1'b0;
        endcase
    end

    assign o_pop = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cspan_pkg::B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row    <= i_job.row_start;
            r_col    <= i_job.col_start;
            r_h      <= 5'd0;
            r_radius <= i_job.radius;
            r_dy     <= 7'd1 - {1'b0, i_job.radius};
            r_dy2    <= cspan_pkg::sq6(i_job.radius - 6'd1);
            r_r2     <= cspan_pkg::sq6(i_job.radius);
            r_value  <= i_job.value;
        end else if (step) begin
            if (grow) begin
                r_h   <= r_h + 5'd1;
                r_col <= (r_col == 12'd0) ? wm1 : r_col - 12'd1;
            end else begin
                r_h   <= r_h - 5'd1;
                r_col <= (r_col == wm1) ? 12'd0 : r_col + 12'd1;
            end
        end else if (emit) begin
            r_dy  <= dy_next;
            r_dy2 <= cspan_pkg::sq6(dy_abs[5:0]);
            r_row <= (r_row == hm1) ? 12'd0 : r_row + 12'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_out_len   <= {r_h, 1'b1};
            r_out_value <= r_value;
            r_out_last  <= is_last;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_row_y        = r_out_row;
    assign o_span_start_x = r_out_col;
    assign o_span_length  = r_out_len;
    assign o_span_value   = r_out_value;
    assign o_last_span    = r_out_last;

endmodule

// ----- design/circle_span_rasterizer.sv -----
`timescale 1ns / 1ps

// Filled circle rasterizer, emitted as horizontal spans.
// Input channel (i_valid / o_stall): one circle per item, center, radius and
// fill word. Radius 0 is taken and dropped; radius above 32 saturates to 32.
// Output channel (o_valid / i_stall): one span per covered row, top to bottom,
// 2r-1 spans per circle, o_last_span set on the bottom one. Rows wrap modulo
// frame_height, start columns modulo frame_width; lengths are not clipped.
// Config channel (i_cfg_valid / o_cfg_ready, always ready): index 0 writes
// frame_width, index 1 frame_height; 0 acts as 1, above 4096 acts as 4096.
// Write config only while idle.
// From accept to hand-off the front wraps center column and first row in a
// shared 14-step remainder unit, and it takes no new circle until that job
// is pushed. The back loads a job, then for each row takes its half-width
// steps and emits the span. A two-entry job queue lets the front prepare the
// next circles while the back is still emitting. The first span follows the
// front's wrapping, the back's load and the top row's half-width steps.
// A stalled output holds its span; the back waits and the queue backs up
// into o_stall.
// Reset (synchronous, active low) empties queue and output, sets 640 x 480.
module circle_span_rasterizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [13:0] i_center_x,
    input  logic [13:0] i_center_y,
    input  logic [5:0]  i_circle_radius,
    input  logic [31:0] i_fill_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [11:0] o_row_y,
    output logic [11:0] o_span_start_x,
    output logic [5:0]  o_span_length,
    output logic [31:0] o_span_value,
    output logic        o_last_span,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [12:0] i_cfg_data
);

    logic [12:0]       r_frame_width;
    logic [12:0]       r_frame_height;
    cspan_pkg::t_frame frame;

    logic              q_push;
    logic              q_full;
    logic              q_pop;
    logic              q_valid;
    cspan_pkg::t_job   front_job;
    cspan_pkg::t_job   q_job;

    // Config port never stalls
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= 13'd640;
            r_frame_height <= 13'd480;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (cspan_pkg::t_cfg_index'(i_cfg_index))
                cspan_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                cspan_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default:                     r_frame_width  <= r_frame_width;
            endcase
        end
    end

    // Clamp once here; both halves see a legal frame size
    assign frame.width  = cspan_pkg::clamp_dim(r_frame_width);
    assign frame.height = cspan_pkg::clamp_dim(r_frame_height);

    cspan_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_center_x      (i_center_x),
        .i_center_y      (i_center_y),
        .i_circle_radius (i_circle_radius),
        .i_fill_value    (i_fill_value),
        .i_frame         (frame),
        .i_q_full        (q_full),
        .o_push          (q_push),
        .o_job           (front_job)
    );

    cspan_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    cspan_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_frame        (frame),
        .i_q_valid      (q_valid),
        .i_job          (q_job),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_row_y        (o_row_y),
        .o_span_start_x (o_span_start_x),
        .o_span_length  (o_span_length),
        .o_span_value   (o_span_value),
        .o_last_span    (o_last_span)
    );

endmodule
